// ===== sv/tmb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_pkg
// shared types and constants of the temporal median background estimator
// ----------------------------------------------------------------------------
package tmb_pkg;

    localparam int MAX_FRAMES_DEF   = 8;
    localparam int NUM_SAMPLES      = 8;
    localparam int FRAME_COUNT_W    = 4;

    typedef logic [7:0]               pixel_t;
    typedef logic [FRAME_COUNT_W-1:0] frame_count_t;

    localparam pixel_t       PAD_VALUE         = 8'hFF;
    localparam frame_count_t FRAME_COUNT_RESET = 4'd5;

endpackage
`default_nettype wire

// ===== sv/tmb_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmb channels
// handshake channels of the median estimator: samples in, median out, config
// ----------------------------------------------------------------------------
interface tmb_pix_if import tmb_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t sample_0;
    pixel_t sample_1;
    pixel_t sample_2;
    pixel_t sample_3;
    pixel_t sample_4;
    pixel_t sample_5;
    pixel_t sample_6;
    pixel_t sample_7;

    modport source (output valid, output sample_0, output sample_1, output sample_2,
                    output sample_3, output sample_4, output sample_5, output sample_6,
                    output sample_7, input ready);
    modport sink   (input valid, input sample_0, input sample_1, input sample_2,
                    input sample_3, input sample_4, input sample_5, input sample_6,
                    input sample_7, output ready);
endinterface

interface tmb_bg_if import tmb_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t median_value;

    modport source (output valid, output median_value, input ready);
    modport sink   (input valid, input median_value, output ready);
endinterface

interface tmb_cfg_if import tmb_pkg::*; ();
    logic         valid;
    logic         ready;
    frame_count_t frame_count;

    modport source (output valid, output frame_count, input ready);
    modport sink   (input valid, input frame_count, output ready);
endinterface
`default_nettype wire

// ===== sv/tmb_sort_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_sort_stage
// one registered layer of an odd-even transposition sorting network
// ----------------------------------------------------------------------------
module tmb_sort_stage import tmb_pkg::*; #(
    parameter int N     = MAX_FRAMES_DEF,
    parameter int IDX_W = 3,
    parameter bit ODD   = 1'b0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pixel_t           in_vals [N],
    input  wire logic [IDX_W-1:0] in_idx,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pixel_t                out_vals [N],
    output logic [IDX_W-1:0]      out_idx
);

    logic             valid_reg;
    pixel_t           vals_reg [N];
    pixel_t           vals_next [N];
    logic [IDX_W-1:0] idx_reg;

    assign in_ready = !valid_reg || out_ready;

    // compare-exchange on pairs starting at the odd or even lane
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            vals_next[i] = in_vals[i];
        end
        for (int i = (ODD ? 1 : 0); i + 1 < N; i += 2)
        begin
            if (in_vals[i] > in_vals[i+1])
            begin
                vals_next[i]   = in_vals[i+1];
                vals_next[i+1] = in_vals[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vals_reg <= vals_next;
            idx_reg  <= in_idx;
        end
    end

    assign out_valid = valid_reg;
    assign out_vals  = vals_reg;
    assign out_idx   = idx_reg;

endmodule
`default_nettype wire

// ===== sv/temporal_median_background.sv =====
`default_nettype none
// throughput: one item per cycle while the sink keeps up; one input register,
// MAX_FRAMES compare-exchange layers and one selection register, all moving on
// a per-stage ready chain
// reset: pipeline emptied, frame_count returns to 5
// ----------------------------------------------------------------------------
// temporal_median_background
// per-pixel median over up to MAX_FRAMES stacked frames, without stalls one pixel per cycle
// ----------------------------------------------------------------------------
module temporal_median_background import tmb_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tmb_cfg_if.sink   cfg,
    tmb_pix_if.sink   pix,
    tmb_bg_if.source  bg
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = 5;

    frame_count_t frame_count_reg;

    logic             stage_valid [MAX_FRAMES+1];
    logic             stage_ready [MAX_FRAMES+2];
    pixel_t           stage_vals  [MAX_FRAMES+1][MAX_FRAMES];
    logic [IDX_W-1:0] stage_idx   [MAX_FRAMES+1];

    pixel_t           samples [NUM_SAMPLES];
    pixel_t           in_vals_next [MAX_FRAMES];
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] count_half;

    logic   in_valid_reg;
    pixel_t in_vals_reg [MAX_FRAMES];
    logic [IDX_W-1:0] in_idx_reg;

    logic   out_valid_reg;
    pixel_t median_reg;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            frame_count_reg <= cfg.frame_count;
        end
    end

    // input stage: clamp count, pad unused slots
    assign samples[0] = pix.sample_0;
    assign samples[1] = pix.sample_1;
    assign samples[2] = pix.sample_2;
    assign samples[3] = pix.sample_3;
    assign samples[4] = pix.sample_4;
    assign samples[5] = pix.sample_5;
    assign samples[6] = pix.sample_6;
    assign samples[7] = pix.sample_7;

    always_comb
    begin
        count_eff = {1'b0, frame_count_reg};
        if (count_eff == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (count_eff > CNT_W'(MAX_FRAMES))
        begin
            count_eff = CNT_W'(MAX_FRAMES);
        end
        count_half = count_eff >> 1;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (i < NUM_SAMPLES && CNT_W'(i) < count_eff)
            begin
                in_vals_next[i] = samples[i % NUM_SAMPLES];
            end
            else
            begin
                in_vals_next[i] = PAD_VALUE;
            end
        end
    end

    assign stage_ready[0] = !in_valid_reg || stage_ready[1];
    assign pix.ready      = stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stage_ready[0])
        begin
            in_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && pix.valid)
        begin
            in_vals_reg <= in_vals_next;
            in_idx_reg  <= count_half[IDX_W-1:0];
        end
    end

    assign stage_valid[0] = in_valid_reg;
    assign stage_vals[0]  = in_vals_reg;
    assign stage_idx[0]   = in_idx_reg;

    // sorting network
    for (genvar k = 1; k <= MAX_FRAMES; k++)
    begin : g_sort
        tmb_sort_stage #(
            .N     (MAX_FRAMES),
            .IDX_W (IDX_W),
            .ODD   (k % 2 == 0)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k-1]),
            .in_ready  (stage_ready[k]),
            .in_vals   (stage_vals[k-1]),
            .in_idx    (stage_idx[k-1]),
            .out_valid (stage_valid[k]),
            .out_ready (stage_ready[k+1]),
            .out_vals  (stage_vals[k]),
            .out_idx   (stage_idx[k])
        );
    end

    // output register picks the median lane
    assign stage_ready[MAX_FRAMES+1] = !out_valid_reg || bg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_ready[MAX_FRAMES+1])
        begin
            out_valid_reg <= stage_valid[MAX_FRAMES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[MAX_FRAMES+1] && stage_valid[MAX_FRAMES])
        begin
            median_reg <= stage_vals[MAX_FRAMES][stage_idx[MAX_FRAMES]];
        end
    end

    assign bg.valid        = out_valid_reg;
    assign bg.median_value = median_reg;

    // checks
    logic sorted_ok;

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int i = 0; i + 1 < MAX_FRAMES; i++)
        begin
            if (stage_vals[MAX_FRAMES][i] > stage_vals[MAX_FRAMES][i+1])
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_network_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[MAX_FRAMES] |-> sorted_ok)
        else $error("last network layer not in ascending order");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pix.ready)
        else $error("input stalled while output register empty");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> (32'(in_idx_reg) <= MAX_FRAMES / 2))
        else $error("median index beyond half the frame limit");

    a_item_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && stage_ready[1]) |=> stage_valid[1])
        else $error("item lost between input register and network");

endmodule
`default_nettype wire

// ===== dv/temporal_median_background_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// temporal_median_background_test
// streams pixel positions of eight stacked frames into the median estimator
// and checks every background value against a sort-and-select predictor,
// across all frame_count settings and a mix of source gaps and sink stalls
// ----------------------------------------------------------------------------
module temporal_median_background_test import tmb_pkg::*; ();

    localparam int CLK_HALF       = 5;
    localparam int PIPE_LATENCY   = MAX_FRAMES_DEF + 2;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 4;
    localparam int NUM_SETTINGS   = 16;
    localparam int NUM_DIRECTED   = 17;
    localparam int ITEMS_PER_RUN  = 108;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    typedef logic [NUM_SAMPLES-1:0][7:0] pixel_set_t;

    localparam pixel_set_t DIRECTED_SETS [NUM_DIRECTED] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'hE0C0_A080_6040_2000,
        64'h0020_4060_80A0_C0E0,
        64'hFF00_FF00_FF00_FF00,
        64'h00FF_00FF_00FF_00FF,
        64'hAA55_AA55_AA55_AA55,
        64'h0000_00C8_C8C8_C8C8,
        64'hFFFF_FF00_0000_0000,
        64'h8080_8080_8080_8080,
        64'h0000_0000_0000_00FF,
        64'h8040_2010_0804_0201,
        64'h0102_0408_1020_4080,
        64'h0000_0003_0107_0502,
        64'h7F7F_7F7F_8001_FE7F,
        64'h0000_0011_3322_4400,
        64'h0000_00FE_01FF_0080
    };

    localparam frame_count_t COUNT_PLAN [NUM_SETTINGS] = '{
        4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd7, 4'd3, 4'd12,
        4'd4, 4'd9, 4'd6, 4'd10, 4'd5, 4'd14, 4'd11, 4'd13
    };

    // holds the expected background values in arrival order
    class median_scoreboard;
        frame_count_t frame_count;
        pixel_t       medians_due[$];
        int           accepted;
        int           checked;
        int           errors;

        function new();
            frame_count = FRAME_COUNT_RESET;
        endfunction

        function void flag(string what, int want, int got);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch: %s expected %0d actual %0d (item %0d)",
                         what, want, got, checked);
        endfunction

        function pixel_t median_of(pixel_set_t s);
            pixel_t frames [MAX_FRAMES_DEF];
            pixel_t key;
            int     n;
            int     i;
            int     j;
            n = int'(frame_count);
            if (n < 1)
                n = 1;
            if (n > MAX_FRAMES_DEF)
                n = MAX_FRAMES_DEF;
            for (i = 0; i < MAX_FRAMES_DEF; i++)
                frames[i] = (i < NUM_SAMPLES) ? s[i] : PAD_VALUE;
            // insertion sort over the participating frames only
            for (i = 1; i < n; i++)
            begin
                key = frames[i];
                j = i;
                while (j > 0 && frames[j-1] > key)
                begin
                    frames[j] = frames[j-1];
                    j--;
                end
                frames[j] = key;
            end
            return frames[n/2];
        endfunction

        function void note_pixels(pixel_set_t s);
            medians_due = {medians_due, median_of(s)};
            accepted++;
        endfunction

        function void check_median(pixel_t got);
            pixel_t want;
            if (medians_due.size() == 0)
            begin
                flag("unexpected median_value, none due", -1, int'(got));
                return;
            end
            want = medians_due.pop_front();
            checked++;
            if (got !== want)
                flag("median_value", int'(want), int'(got));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_gap_pct;
    int   recv_stall_pct;
    int   cycles;

    median_scoreboard sb;

    tmb_cfg_if cfg_ch ();
    tmb_pix_if pix_ch ();
    tmb_bg_if  bg_ch ();

    temporal_median_background dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .pix   (pix_ch),
        .bg    (bg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("temporal_median_background_test failed");
            $finish;
        end
    end

    // handshakes are taken at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.frame_count = cfg_ch.frame_count;
            if (bg_ch.valid && bg_ch.ready)
                sb.check_median(bg_ch.median_value);
            if (pix_ch.valid && pix_ch.ready)
                sb.note_pixels({pix_ch.sample_7, pix_ch.sample_6, pix_ch.sample_5,
                                pix_ch.sample_4, pix_ch.sample_3, pix_ch.sample_2,
                                pix_ch.sample_1, pix_ch.sample_0});
        end
    end

    // result side back-pressure
    initial
    begin
        bg_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            bg_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic pixel_set_t random_pixels();
        pixel_set_t s;
        int         style;
        int         base;
        int         t;
        int         k;
        pixel_t     va;
        pixel_t     vb;
        style = $urandom_range(9);
        base  = $urandom_range(255);
        va    = pixel_t'($urandom);
        vb    = pixel_t'($urandom);
        for (k = 0; k < NUM_SAMPLES; k++)
        begin
            if (style <= 3)
                s[k] = pixel_t'($urandom);
            else if (style <= 6)
            begin
                // clustered around one grey level, as a static background is
                t = base + int'($urandom_range(16)) - 8;
                if (t < 0)
                    t = 0;
                if (t > 255)
                    t = 255;
                s[k] = pixel_t'(t);
            end
            else if (style <= 8)
                s[k] = $urandom_range(1) ? va : vb;
            else
            begin
                case ($urandom_range(2))
                    0: s[k] = 8'h00;
                    1: s[k] = 8'hFF;
                    default: s[k] = pixel_t'($urandom);
                endcase
            end
        end
        return s;
    endfunction

    task automatic send_pixels(input pixel_set_t s);
        while ($urandom_range(99) < send_gap_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.sample_0 <= s[0];
        pix_ch.sample_1 <= s[1];
        pix_ch.sample_2 <= s[2];
        pix_ch.sample_3 <= s[3];
        pix_ch.sample_4 <= s[4];
        pix_ch.sample_5 <= s[5];
        pix_ch.sample_6 <= s[6];
        pix_ch.sample_7 <= s[7];
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_frame_count(input frame_count_t value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.frame_count <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // source holds off until the pipeline has handed back everything
    task automatic await_medians();
        pix_ch.valid <= 1'b0;
        @(negedge clk);
        while (sb.medians_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int n;

        sb = new();
        send_gap_pct       = 0;
        recv_stall_pct     = 0;
        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.frame_count = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.sample_0    = '0;
        pix_ch.sample_1    = '0;
        pix_ch.sample_2    = '0;
        pix_ch.sample_3    = '0;
        pix_ch.sample_4    = '0;
        pix_ch.sample_5    = '0;
        pix_ch.sample_6    = '0;
        pix_ch.sample_7    = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items run at the reset frame count
        for (n = 0; n < NUM_DIRECTED; n++)
            send_pixels(DIRECTED_SETS[n]);

        for (phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            await_medians();
            write_frame_count(COUNT_PLAN[phase]);
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 50; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 50; end
                default: begin send_gap_pct = 14; recv_stall_pct = 14; end
            endcase
            for (n = 0; n < ITEMS_PER_RUN; n++)
                send_pixels(random_pixels());
        end

        await_medians();
        if (sb.medians_due.size() != 0)
            sb.flag("medians still outstanding", 0, sb.medians_due.size());

        $display("run covered %0d pixel items over all %0d frame_count settings",
                 sb.accepted, NUM_SETTINGS);
        $display("with source gaps and sink stalls mixed; %0d medians checked, %0d errors",
                 sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("temporal_median_background_test passed");
        else
            $display("temporal_median_background_test failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/tmb_pkg.sv
sv/tmb_if.sv
sv/tmb_sort_stage.sv
sv/temporal_median_background.sv
dv/temporal_median_background_test.sv
